// ----- src/mscont_pkg.sv -----
// mscont_pkg: shared types, constants and the segment table of the contour block
// used by every module in src; depends on nothing else

package mscont_pkg;

   localparam int GRID_COLS_DEFAULT = 64;
   localparam int GRID_ROWS_DEFAULT = 64;

   localparam int COORD_W  = 7;   // request col / row
   localparam int CELL_W   = 6;   // result cell_col / cell_row
   localparam int RADIUS_W = 4;
   localparam int OFF_W    = 5;   // signed walk offset, covers -15..15
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd3;

   // register index (paddr above the byte lanes)
   localparam logic [PADDR_W-3:0] REG_BRUSH_RADIUS = 1'b0;

   // request opcodes
   localparam logic OP_PAINT   = 1'b0;
   localparam logic OP_CONTOUR = 1'b1;

   // edge midpoint codes
   localparam logic [1:0] EDGE_TOP    = 2'd0;
   localparam logic [1:0] EDGE_RIGHT  = 2'd1;
   localparam logic [1:0] EDGE_BOTTOM = 2'd2;
   localparam logic [1:0] EDGE_LEFT   = 2'd3;

   typedef struct packed {
      logic                op;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic                paint_value;
   } req_type;

   typedef struct packed {
      logic               segment_valid;
      logic [CELL_W-1:0]  cell_col;
      logic [CELL_W-1:0]  cell_row;
      logic [3:0]         case_index;
      logic [1:0]         start_edge;
      logic [1:0]         end_edge;
      logic               last;
   } rsp_type;

   // status of one grid point from the point unit
   typedef struct packed {
      logic in_grid;
      logic in_disc;
   } point_status_type;

   typedef struct packed {
      logic [1:0] count;
      logic [1:0] start0;
      logic [1:0] end0;
      logic [1:0] start1;
      logic [1:0] end1;
   } seg_entry_type;

   localparam seg_entry_type SEG_TABLE [16] = '{
      '{2'd0, EDGE_TOP,    EDGE_TOP,    EDGE_TOP,    EDGE_TOP},
      '{2'd1, EDGE_BOTTOM, EDGE_LEFT,   EDGE_TOP,    EDGE_TOP},
      '{2'd1, EDGE_RIGHT,  EDGE_BOTTOM, EDGE_TOP,    EDGE_TOP},
      '{2'd1, EDGE_RIGHT,  EDGE_LEFT,   EDGE_TOP,    EDGE_TOP},
      '{2'd1, EDGE_TOP,    EDGE_RIGHT,  EDGE_TOP,    EDGE_TOP},
      '{2'd2, EDGE_TOP,    EDGE_LEFT,   EDGE_RIGHT,  EDGE_BOTTOM},
      '{2'd1, EDGE_TOP,    EDGE_BOTTOM, EDGE_TOP,    EDGE_TOP},
      '{2'd1, EDGE_TOP,    EDGE_LEFT,   EDGE_TOP,    EDGE_TOP},
      '{2'd1, EDGE_TOP,    EDGE_LEFT,   EDGE_TOP,    EDGE_TOP},
      '{2'd1, EDGE_TOP,    EDGE_BOTTOM, EDGE_TOP,    EDGE_TOP},
      '{2'd2, EDGE_TOP,    EDGE_RIGHT,  EDGE_BOTTOM, EDGE_LEFT},
      '{2'd1, EDGE_TOP,    EDGE_RIGHT,  EDGE_TOP,    EDGE_TOP},
      '{2'd1, EDGE_RIGHT,  EDGE_LEFT,   EDGE_TOP,    EDGE_TOP},
      '{2'd1, EDGE_RIGHT,  EDGE_BOTTOM, EDGE_TOP,    EDGE_TOP},
      '{2'd1, EDGE_BOTTOM, EDGE_LEFT,   EDGE_TOP,    EDGE_TOP},
      '{2'd0, EDGE_TOP,    EDGE_TOP,    EDGE_TOP,    EDGE_TOP}
   };

endpackage

// ----- src/mscont_grid_mem.sv -----
// mscont_grid_mem: one-bit point grid memory, one write and one registered read port
// clears itself after reset, one point a cycle; uses mscont_pkg for its parameter defaults

module mscont_grid_mem #(
   parameter int DEPTH = (mscont_pkg::GRID_COLS_DEFAULT + 1) * (mscont_pkg::GRID_ROWS_DEFAULT + 1),
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data,
   output logic          clr_busy
);

   logic          mem [DEPTH];
   logic          rd_data_ff;
   logic          clr_busy_ff;
   logic          clr_busy_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= 1'b0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

// ----- src/mscont_point_unit.sv -----
// mscont_point_unit: shared point unit, base + offset to grid address, bounds and disc test
// depends on mscont_pkg

module mscont_point_unit #(
   parameter int GRID_COLS = mscont_pkg::GRID_COLS_DEFAULT,
   parameter int GRID_ROWS = mscont_pkg::GRID_ROWS_DEFAULT,
   parameter int AW        = $clog2((GRID_COLS + 1) * (GRID_ROWS + 1))
) (
   input  logic [mscont_pkg::COORD_W-1:0]        base_col,
   input  logic [mscont_pkg::COORD_W-1:0]        base_row,
   input  logic signed [mscont_pkg::OFF_W-1:0]   off_x,
   input  logic signed [mscont_pkg::OFF_W-1:0]   off_y,
   input  logic [mscont_pkg::RADIUS_W-1:0]       radius,
   output logic [AW-1:0]                         pt_addr,
   output mscont_pkg::point_status_type          status
);

   localparam int PtCols   = GRID_COLS + 1;
   localparam int PtRows   = GRID_ROWS + 1;
   localparam int SpanMax  = (PtCols > PtRows) ? PtCols : PtRows;
   localparam int ReachMax = 2 ** mscont_pkg::COORD_W + 2 ** (mscont_pkg::OFF_W - 1);
   localparam int CoordMax = (SpanMax > ReachMax) ? SpanMax : ReachMax;
   localparam int CW       = $clog2(CoordMax + 1) + 1;

   logic signed [CW-1:0] x_pt;
   logic signed [CW-1:0] y_pt;
   logic [CW-2:0]        x_u;
   logic [CW-2:0]        y_u;
   logic [3:0]           mag_x;
   logic [3:0]           mag_y;
   logic [7:0]           sq_x;
   logic [7:0]           sq_y;
   logic [7:0]           sq_r;
   logic [8:0]           dist_sq;

   assign x_pt = $signed(CW'(base_col)) + CW'(off_x);
   assign y_pt = $signed(CW'(base_row)) + CW'(off_y);
   assign x_u  = x_pt[CW-2:0];
   assign y_u  = y_pt[CW-2:0];

   // linear address, row major
   assign pt_addr = AW'(AW'(y_u) * AW'(PtCols) + AW'(x_u));

   assign status.in_grid = !x_pt[CW-1] && !y_pt[CW-1]
                        && (x_pt < $signed(CW'(PtCols)))
                        && (y_pt < $signed(CW'(PtRows)));

   // integer disc test dx*dx + dy*dy <= r*r
   assign mag_x   = off_x[mscont_pkg::OFF_W-1] ? 4'(-off_x) : 4'(off_x);
   assign mag_y   = off_y[mscont_pkg::OFF_W-1] ? 4'(-off_y) : 4'(off_y);
   assign sq_x    = 8'(mag_x) * 8'(mag_x);
   assign sq_y    = 8'(mag_y) * 8'(mag_y);
   assign sq_r    = 8'(radius) * 8'(radius);
   assign dist_sq = 9'(sq_x) + 9'(sq_y);

   assign status.in_disc = (dist_sq <= 9'(sq_r));

endmodule

// ----- src/marching_squares_contour_top.sv -----
// marching_squares_contour_top: paintable point grid with marching-squares cell queries
// instantiates mscont_point_unit and mscont_grid_mem; types and table from mscont_pkg
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_ready  req_data  (op, col, row, paint_value)
//   rsp       out        rsp_valid / rsp_ready  rsp_data  (one or two per contour request)
//   csr       in/out     psel penable pwrite    paddr pwdata prdata, pready tied high
//
// a paint request walks the (2r+1)^2 square around its centre, one point a cycle
// through the shared point unit and the single memory write port, and returns to
// idle before the next request is taken
// a contour request reads its four corners through the one read port in the read
// state, then gives one or two results, one per cycle while rsp_ready is high; an
// out of range cell skips the reads and gives a single result
// after reset the grid is swept to zero, one point a cycle over all
// (GRID_COLS+1)*(GRID_ROWS+1) points (4225 by default); req_ready stays low until the sweep is done
// a stalled rsp holds the result stage; after the last result loads, a paint request is still taken

module marching_squares_contour_top #(
   parameter int GRID_COLS = mscont_pkg::GRID_COLS_DEFAULT,
   parameter int GRID_ROWS = mscont_pkg::GRID_ROWS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  mscont_pkg::req_type                req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output mscont_pkg::rsp_type                rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mscont_pkg::PADDR_W-1:0]     paddr,
   input  logic [mscont_pkg::PDATA_W-1:0]     pwdata,
   output logic [mscont_pkg::PDATA_W-1:0]     prdata,
   output logic                               pready
);

   localparam int PtCols = GRID_COLS + 1;
   localparam int PtRows = GRID_ROWS + 1;
   localparam int Depth  = PtCols * PtRows;
   localparam int AW     = $clog2(Depth);
   localparam int GW     = $clog2((GRID_COLS > GRID_ROWS ? GRID_COLS : GRID_ROWS)
                                  + 2 ** mscont_pkg::COORD_W) + 1;
   localparam int OW     = mscont_pkg::OFF_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PAINT = 4'b0010,
      ST_READ  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type                              state_ff, state_in;
   logic [mscont_pkg::COORD_W-1:0]         col_ff, col_in;
   logic [mscont_pkg::COORD_W-1:0]         row_ff, row_in;
   logic                                   value_ff, value_in;
   logic                                   oor_ff, oor_in;
   logic signed [OW-1:0]                   dx_ff, dx_in;
   logic signed [OW-1:0]                   dy_ff, dy_in;
   logic [2:0]                             corner_ff, corner_in;
   logic [3:0]                             case_ff, case_in;
   logic                                   seg_ff, seg_in;
   logic [mscont_pkg::RADIUS_W-1:0]        radius_ff, radius_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   mscont_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   logic                                   req_accept;
   logic                                   rsp_load;
   logic                                   cfg_write;
   logic [mscont_pkg::PADDR_W-3:0]         cfg_index;
   logic signed [OW-1:0]                   radius_s;
   logic signed [OW-1:0]                   off_x;
   logic signed [OW-1:0]                   off_y;
   logic                                   out_of_range;
   logic [AW-1:0]                          pt_addr;
   mscont_pkg::point_status_type           pt_status;
   logic                                   mem_wr_en;
   logic                                   mem_rd_data;
   logic                                   clr_busy;
   mscont_pkg::seg_entry_type              entry;
   logic                                   final_result;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_index = paddr[mscont_pkg::PADDR_W-1:2];

   always_comb begin
      prdata = '0;
      if (cfg_index == mscont_pkg::REG_BRUSH_RADIUS) begin
         prdata = mscont_pkg::PDATA_W'(radius_ff);
      end
   end

   // ---------------- request side ----------------
   assign req_ready  = (state_ff == ST_IDLE) && !clr_busy;
   assign req_accept = req_valid && req_ready;
   assign radius_s   = $signed({1'b0, radius_ff});

   // cell must leave room for its right and bottom corners
   assign out_of_range = (GW'(req_data.col) >= GW'(GRID_COLS))
                      || (GW'(req_data.row) >= GW'(GRID_ROWS));

   // corner walk TL, TR, BR, BL so the case bits shift in msb first
   always_comb begin
      off_x = dx_ff;
      off_y = dy_ff;
      if (state_ff == ST_READ) begin
         off_x = ((corner_ff == 3'd1) || (corner_ff == 3'd2)) ? OW'(1) : OW'(0);
         off_y = ((corner_ff == 3'd2) || (corner_ff == 3'd3)) ? OW'(1) : OW'(0);
      end
   end

   mscont_point_unit #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS),
      .AW        (AW)
   ) u_point (
      .base_col (col_ff),
      .base_row (row_ff),
      .off_x    (off_x),
      .off_y    (off_y),
      .radius   (radius_ff),
      .pt_addr  (pt_addr),
      .status   (pt_status)
   );

   // only points inside both the grid and the disc get painted
   assign mem_wr_en = (state_ff == ST_PAINT) && pt_status.in_grid && pt_status.in_disc;

   mscont_grid_mem #(
      .DEPTH (Depth),
      .AW    (AW)
   ) u_grid (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (mem_wr_en),
      .wr_addr  (pt_addr),
      .wr_data  (value_ff),
      .rd_addr  (pt_addr),
      .rd_data  (mem_rd_data),
      .clr_busy (clr_busy)
   );

   // ---------------- result side ----------------
   assign entry    = mscont_pkg::SEG_TABLE[case_ff];
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // empty, single-segment and out of range cells give a single result; only two-segment cells give two
   assign final_result = oor_ff || (entry.count != 2'd2) || seg_ff;

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in.last = final_result;
      if (!oor_ff) begin
         rsp_data_in.segment_valid = (entry.count != 2'd0);
         rsp_data_in.cell_col      = col_ff[mscont_pkg::CELL_W-1:0];
         rsp_data_in.cell_row      = row_ff[mscont_pkg::CELL_W-1:0];
         rsp_data_in.case_index    = case_ff;
         if (entry.count != 2'd0) begin
            rsp_data_in.start_edge = seg_ff ? entry.start1 : entry.start0;
            rsp_data_in.end_edge   = seg_ff ? entry.end1 : entry.end0;
         end
      end
      if (!rsp_load) begin
         rsp_data_in = rsp_data_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      value_in  = value_ff;
      oor_in    = oor_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      corner_in = corner_ff;
      case_in   = case_ff;
      seg_in    = seg_ff;
      radius_in = radius_ff;

      if (cfg_write && (cfg_index == mscont_pkg::REG_BRUSH_RADIUS)) begin
         radius_in = pwdata[mscont_pkg::RADIUS_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               col_in    = req_data.col;
               row_in    = req_data.row;
               value_in  = req_data.paint_value;
               oor_in    = out_of_range;
               dx_in     = -radius_s;
               dy_in     = -radius_s;
               corner_in = '0;
               seg_in    = 1'b0;
               if (req_data.op == mscont_pkg::OP_PAINT) begin
                  state_in = ST_PAINT;
               end else if (out_of_range) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_PAINT: begin
            // raster walk over the bounding square of the disc
            if (dx_ff == radius_s) begin
               dx_in = -radius_s;
               if (dy_ff == radius_s) begin
                  state_in = ST_IDLE;
               end else begin
                  dy_in = dy_ff + OW'(1);
               end
            end else begin
               dx_in = dx_ff + OW'(1);
            end
         end
         ST_READ: begin
            // read data is registered and arrives in the cycle after its address
            corner_in = corner_ff + 3'd1;
            if (corner_ff != 3'd0) begin
               case_in = {case_ff[2:0], mem_rd_data};
            end
            if (corner_ff == 3'd4) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               if (final_result) begin
                  state_in = ST_IDLE;
               end else begin
                  seg_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= mscont_pkg::RADIUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      value_ff    <= value_in;
      oor_ff      <= oor_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      corner_ff   <= corner_in;
      case_ff     <= case_in;
      seg_ff      <= seg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- checks ----------------
   // no request while the grid is still being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_ready)
      else $error("request taken during grid clear");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ready)
      else $error("ready stayed high after accept");

   // only the first of two segments can be non-final
   a_nonlast_is_segment: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.segment_valid)
      else $error("non-final result without a segment");

   // a segment never joins an edge to itself
   a_segment_edges_differ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.segment_valid |-> rsp_data.start_edge != rsp_data.end_edge)
      else $error("degenerate segment");

   // no memory write outside a paint walk
   a_write_only_in_paint: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> state_ff == ST_PAINT && !clr_busy)
      else $error("grid write outside paint");

endmodule
